// File: hw/rtl/char_lcd_nibble_bus_writer_assert.svh
// assertion macros used by clnbw_back
`ifndef CHAR_LCD_NIBBLE_BUS_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_BUS_WRITER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define CLNBW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define CLNBW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/clnbw_pkg.sv
package clnbw_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] OP_NUM_AT   = 3'd0;
	localparam logic [2:0] OP_CHAR_AT  = 3'd1;
	localparam logic [2:0] OP_CHAR_CUR = 3'd2;
	localparam logic [2:0] OP_CMD      = 3'd3;
	localparam logic [2:0] OP_INIT     = 3'd4;

	localparam logic [1:0] WAIT_NONE  = 2'd0;
	localparam logic [1:0] WAIT_150US = 2'd1;
	localparam logic [1:0] WAIT_5MS   = 2'd2;
	localparam logic [1:0] WAIT_48MS  = 2'd3;

	localparam logic [7:0] POS_ROW0   = 8'h80;
	localparam logic [7:0] POS_ROW1   = 8'hC0;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [3:0] NIB_WAKE   = 4'h3;
	localparam logic [3:0] NIB_4BIT   = 4'h2;
	localparam logic [7:0] CMD_FUNC   = 8'h28;
	localparam logic [7:0] CMD_DISP   = 8'h0F;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_ENTRY  = 8'h06;
	localparam logic [7:0] CMD_HOME   = 8'h02;

	localparam logic [3:0] LAST_STEP_NUM  = 4'd11;
	localparam logic [3:0] LAST_STEP_AT   = 4'd3;
	localparam logic [3:0] LAST_STEP_BYTE = 4'd1;

	typedef enum logic [2:0] {
		K_NUM,
		K_CHAR_AT,
		K_CHAR_CUR,
		K_CMD,
		K_INIT
	} kind_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] number;
		logic [7:0]  byte_value;
		logic        row;
		logic [5:0]  col;
	} cmd_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       rs;
		logic [1:0] wait_before;
		logic       last;
	} xfer_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pos;
		logic [7:0]  byte_value;
		logic [15:0] number;
	} req_t;

	typedef struct packed {
		logic push;
		req_t entry;
	} q_wr_t;

	function automatic logic [13:0] digit_weight(input logic [2:0] idx);
		logic [13:0] w;
		case (idx)
			3'd0: w = 14'd10000;
			3'd1: w = 14'd1000;
			3'd2: w = 14'd100;
			3'd3: w = 14'd10;
			default: w = 14'd1;
		endcase
		return w;
	endfunction

	function automatic xfer_t init_xfer(input logic [3:0] s);
		xfer_t x;
		logic [7:0] b;
		case (s[3:1])
			3'd2: b = CMD_FUNC;
			3'd3: b = CMD_DISP;
			3'd4: b = CMD_CLEAR;
			3'd5: b = CMD_ENTRY;
			3'd6: b = CMD_HOME;
			default: b = CMD_CLEAR;
		endcase
		x.rs = 1'b0;
		x.last = (s == 4'd15);
		x.nibble = s[0] ? b[3:0] : b[7:4];
		x.wait_before = WAIT_NONE;
		case (s)
			4'd0: begin
				x.nibble = NIB_WAKE;
				x.wait_before = WAIT_48MS;
			end
			4'd1: begin
				x.nibble = NIB_WAKE;
				x.wait_before = WAIT_5MS;
			end
			4'd2: begin
				x.nibble = NIB_WAKE;
				x.wait_before = WAIT_150US;
			end
			4'd3: begin
				x.nibble = NIB_4BIT;
			end
			default: begin
			end
		endcase
		return x;
	endfunction

endpackage

// File: hw/rtl/char_lcd_nibble_bus_writer.sv
// channel | port set                        | word
// in      | cmd_valid / cmd_stall / cmd      | cmd_t: op, number, byte_value, row, col
// out     | xfer_valid / xfer_stall / xfer   | xfer_t: nibble, rs, wait_before, last
//
// one nibble word leaves per cycle while the output is not stalled
// a request sends 2, 4, 12 or 16 nibble words (char/command, char at position, number, init)
// the back sequencer starts the next queued request in the cycle of the last word
// arst_n clears queue and sequencer; cmd_stall is high while the queue is full
// number digits come from the remainder register, one per character
module char_lcd_nibble_bus_writer #(
	parameter int QDEPTH = clnbw_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  clnbw_pkg::cmd_t   cmd,
	output logic              xfer_valid,
	input  logic              xfer_stall,
	output clnbw_pkg::xfer_t  xfer
);
	import clnbw_pkg::*;

	q_wr_t q_wr;
	logic  q_full;
	logic  head_valid;
	req_t  head;
	logic  pop;

	clnbw_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_wr      (q_wr)
	);

	clnbw_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_wr       (q_wr),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	clnbw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.xfer_valid (xfer_valid),
		.xfer_stall (xfer_stall),
		.xfer       (xfer)
	);

endmodule

// File: hw/rtl/clnbw_front.sv
module clnbw_front (
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  clnbw_pkg::cmd_t   cmd,
	input  logic              q_full,
	output clnbw_pkg::q_wr_t  q_wr
);
	import clnbw_pkg::*;

	logic known;

	always_comb begin
		known = 1'b1;
		q_wr.entry.kind = K_CMD;
		case (cmd.op)
			OP_NUM_AT:   q_wr.entry.kind = K_NUM;
			OP_CHAR_AT:  q_wr.entry.kind = K_CHAR_AT;
			OP_CHAR_CUR: q_wr.entry.kind = K_CHAR_CUR;
			OP_CMD:      q_wr.entry.kind = K_CMD;
			OP_INIT:     q_wr.entry.kind = K_INIT;
			default:     known = 1'b0;
		endcase
		q_wr.entry.pos = (cmd.row ? POS_ROW1 : POS_ROW0) | {2'b00, cmd.col};
		q_wr.entry.byte_value = cmd.byte_value;
		q_wr.entry.number = cmd.number;
		// unknown ops are taken and dropped
		q_wr.push = cmd_valid && !q_full && known;
	end

	assign cmd_stall = q_full;

endmodule

// File: hw/rtl/clnbw_queue.sv
module clnbw_queue #(
	parameter int DEPTH = clnbw_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clnbw_pkg::q_wr_t  q_wr,
	output logic              full,
	output logic              head_valid,
	output clnbw_pkg::req_t   head,
	input  logic              pop
);
	import clnbw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	req_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.entry;
		end
	end

endmodule

// File: hw/rtl/clnbw_back.sv
module clnbw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  clnbw_pkg::req_t   head,
	output logic              pop,
	output logic              xfer_valid,
	input  logic              xfer_stall,
	output clnbw_pkg::xfer_t  xfer
);
	import clnbw_pkg::*;
	`include "char_lcd_nibble_bus_writer_assert.svh"

	req_t        cur_q;
	logic        busy_q;
	logic [3:0]  step_q;
	logic [15:0] rem_q;
	logic        seen_q;
	logic [3:0]  lo_q;
	logic        xfer_valid_q;
	xfer_t       xfer_q;

	xfer_t       gen;
	logic        advance;
	logic        load;
	logic        digit_hi;
	logic [3:0]  step_off;
	logic [13:0] wgt;
	logic [3:0]  dig;
	logic        blank;
	logic [16:0] sub;

	// one decimal digit of the remainder per character
	always_comb begin
		step_off = step_q - 4'd2;
		wgt = digit_weight(step_off[3:1]);
		dig = 4'd0;
		for (int m = 1; m <= 9; m++) begin
			if ({1'b0, rem_q} >= 17'(m) * {3'b000, wgt}) begin
				dig = 4'(m);
			end
		end
		sub = {13'd0, dig} * {3'b000, wgt};
		blank = (step_off[3:1] != 3'd4) && (dig == 4'd0) && !seen_q;
		digit_hi = (cur_q.kind == K_NUM) && (step_q >= 4'd2) && !step_q[0];
	end

	always_comb begin
		gen.nibble = 4'd0;
		gen.rs = 1'b0;
		gen.wait_before = WAIT_NONE;
		gen.last = 1'b0;
		case (cur_q.kind)
			K_CMD, K_CHAR_CUR: begin
				gen.nibble = step_q[0] ? cur_q.byte_value[3:0] : cur_q.byte_value[7:4];
				gen.rs = (cur_q.kind == K_CHAR_CUR);
				gen.last = (step_q == LAST_STEP_BYTE);
			end
			K_CHAR_AT: begin
				if (step_q[1]) begin
					gen.nibble = step_q[0] ? cur_q.byte_value[3:0] : cur_q.byte_value[7:4];
					gen.rs = 1'b1;
				end else begin
					gen.nibble = step_q[0] ? cur_q.pos[3:0] : cur_q.pos[7:4];
				end
				gen.last = (step_q == LAST_STEP_AT);
			end
			K_NUM: begin
				if (step_q < 4'd2) begin
					gen.nibble = step_q[0] ? cur_q.pos[3:0] : cur_q.pos[7:4];
				end else if (!step_q[0]) begin
					gen.nibble = blank ? CHR_SPACE[7:4] : CHR_ZERO[7:4];
					gen.rs = 1'b1;
				end else begin
					gen.nibble = lo_q;
					gen.rs = 1'b1;
				end
				gen.last = (step_q == LAST_STEP_NUM);
			end
			K_INIT: begin
				gen = init_xfer(step_q);
			end
			default: begin
			end
		endcase
	end

	assign advance = busy_q && (!xfer_valid_q || !xfer_stall);
	assign load    = head_valid && (!busy_q || (advance && gen.last));
	assign pop     = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			step_q       <= 4'd0;
			seen_q       <= 1'b0;
			xfer_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				xfer_valid_q <= 1'b1;
			end else if (!xfer_stall) begin
				xfer_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				step_q <= 4'd0;
				seen_q <= 1'b0;
			end else if (advance) begin
				if (gen.last) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 4'd1;
				end
				if (digit_hi && !blank) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			xfer_q <= gen;
		end
		if (load) begin
			cur_q <= head;
			rem_q <= head.number;
		end else if (advance && digit_hi) begin
			rem_q <= rem_q - sub[15:0];
			lo_q  <= blank ? CHR_SPACE[3:0] : CHR_ZERO[3:0] + dig;
		end
	end

	assign xfer_valid = xfer_valid_q;
	assign xfer       = xfer_q;

	`CLNBW_ASSERT_NOW(a_byte_steps, busy_q && (cur_q.kind == K_CMD || cur_q.kind == K_CHAR_CUR), step_q <= LAST_STEP_BYTE, "byte op ran past its second nibble")
	`CLNBW_ASSERT_NOW(a_num_steps, busy_q && cur_q.kind == K_NUM, step_q <= LAST_STEP_NUM, "number op ran past its last nibble")
	`CLNBW_ASSERT_NEXT(a_step_hold, busy_q && !advance, $stable(step_q), "step moved while output blocked")
	`CLNBW_ASSERT_NEXT(a_idle_drain, xfer_valid_q && !xfer_stall && !busy_q, !xfer_valid_q, "word shown with no request in progress")

endmodule
